/* rtl/core/eeg_pkg.sv */
// Package for the extended Euclid GCD core: shared widths and the sequencer state type.
// No dependencies; imported by eeg_multiplier and extended_euclid_gcd_core.
`default_nettype none

package eeg_pkg;

    localparam int FIELD_W = 31;   // input operand field width
    localparam int GCD_W   = 31;   // gcd result field width
    localparam int COEFF_W = 32;   // Bezout coefficient width, two's complement

    typedef logic [COEFF_W-1:0] coeff_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_U,
        ST_SUB_U,
        ST_MUL_V,
        ST_SUB_V,
        ST_FINISH
    } eeg_state_t;

endpackage

`default_nettype wire

/* rtl/core/eeg_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by extended_euclid_gcd_core.
`default_nettype none

module eeg_divider
#(
    parameter int WIDTH = 31
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic      [WIDTH-1:0] quotient,
    output logic      [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;

    // Shift in the next dividend bit and try one subtraction.
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/eeg_multiplier.sv */
// Registered low-half multiplier: quotient times coefficient, modulo 2^COEFF_W.
// Depends on eeg_pkg; used by extended_euclid_gcd_core.
`default_nettype none

module eeg_multiplier
    import eeg_pkg::*;
#(
    parameter int Q_W = 31
)
(
    input  wire logic           clk,
    input  wire logic           load,
    input  wire logic [Q_W-1:0] quotient,
    input  wire coeff_t         multiplicand,
    output coeff_t              product
);

    coeff_t prod_reg;
    coeff_t prod_next;

    // Only the low half matters: coefficients wrap modulo 2^COEFF_W.
    assign prod_next = COEFF_W'(quotient) * multiplicand;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

/* rtl/core/extended_euclid_gcd_core.sv */
// Extended Euclid GCD core: returns gcd(a, b) and Bezout coefficients u, v with a*u + b*v = g.
// Top level; depends on eeg_pkg, eeg_divider and eeg_multiplier.
//
// One transaction in gives one transaction out. Operands are truncated to
// min(31, OPERAND_WIDTH-1) bits. The core handles one pair at a time: in_ready
// is high only while the sequencer is idle. Each Euclid round runs the shared
// restoring divider (one quotient bit per cycle), then the shared multiplier
// twice (u and v updates, each a multiply state then a subtract state), plus a
// loop test on the remainder. When b is zero the result is g = a, u = 1, v = 0
// with zero_divisor set; a = 0 with nonzero b yields g = b, u = 0, v = 1. The
// finished result sits in an output register, so a new pair is accepted while
// the old result still waits.
`default_nettype none

module extended_euclid_gcd_core
    import eeg_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FIELD_W-1:0] a_value,
    input  wire logic [FIELD_W-1:0] b_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [GCD_W-1:0]   gcd_out,
    output logic      [COEFF_W-1:0] coeff_a,
    output logic      [COEFF_W-1:0] coeff_b,
    output logic                    zero_divisor
);

    // Effective operand width: masked by both the field and the parameter.
    localparam int OP_W = (OPERAND_WIDTH - 1 < FIELD_W) ? (OPERAND_WIDTH - 1) : FIELD_W;

    eeg_state_t state_reg, state_next;

    // Remainder pair and both coefficient pairs of the recurrence.
    logic [OP_W-1:0] g_reg, y_reg;
    coeff_t          u_reg, x_reg, v_reg, w_reg;
    logic            err_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [GCD_W-1:0]   gcd_reg;
    coeff_t             ca_reg, cb_reg;
    logic               zd_reg;

    // Sequencer controls.
    logic   accept;
    logic   div_start;
    logic   mul_load;
    logic   out_load;
    coeff_t mul_operand;

    logic [OP_W-1:0] div_quo, div_rem;
    logic            div_done;
    coeff_t          product;

    assign accept = in_valid && in_ready;

    eeg_divider
    #(
        .WIDTH (OP_W)
    )
    u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (g_reg),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    eeg_multiplier
    #(
        .Q_W (OP_W)
    )
    u_multiplier
    (
        .clk          (clk),
        .load         (mul_load),
        .quotient     (div_quo),
        .multiplicand (mul_operand),
        .product      (product)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (y_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_U;
                end
            end
            ST_MUL_U: state_next = ST_SUB_U;
            ST_SUB_U: state_next = ST_MUL_V;
            ST_MUL_V: state_next = ST_SUB_V;
            ST_SUB_V: state_next = ST_CHECK;
            ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        mul_load    = 1'b0;
        out_load    = 1'b0;
        mul_operand = x_reg;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_CHECK: div_start = (y_reg != '0);
            ST_MUL_U: mul_load = 1'b1;
            ST_MUL_V:
            begin
                mul_load    = 1'b1;
                mul_operand = w_reg;
            end
            ST_FINISH: out_load = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Recurrence datapath; a zero b simply skips the loop.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g_reg   <= a_value[OP_W-1:0];
            y_reg   <= b_value[OP_W-1:0];
            u_reg   <= COEFF_W'(1);
            x_reg   <= '0;
            v_reg   <= '0;
            w_reg   <= COEFF_W'(1);
            err_reg <= (b_value[OP_W-1:0] == '0);
        end
        else if (state_reg == ST_SUB_U)
        begin
            u_reg <= x_reg;
            x_reg <= u_reg - product;
        end
        else if (state_reg == ST_SUB_V)
        begin
            v_reg <= w_reg;
            w_reg <= v_reg - product;
            g_reg <= y_reg;
            y_reg <= div_rem;
        end
    end

    // Output register: drop valid on handshake, raise it on a finished pair.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gcd_reg <= GCD_W'(g_reg);
            ca_reg  <= u_reg;
            cb_reg  <= v_reg;
            zd_reg  <= err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign gcd_out      = gcd_reg;
    assign coeff_a      = ca_reg;
    assign coeff_b      = cb_reg;
    assign zero_divisor = zd_reg;

endmodule

`default_nettype wire
